// ===== sv/wmm_pkg.sv =====
// Package for the wildcard motif match and count accumulate block.
// Holds the word types, register and operation codes, and fixed sizes.
// No dependencies.
`default_nettype none

package wmm_pkg;

   localparam int RES_W       = 5;
   localparam int RES_NUM     = 12;
   localparam int PEPTIDE_LEN = 12;
   localparam int PEP_W       = RES_W * RES_NUM;
   localparam int BIN_W       = 11;
   localparam int BIN_EXT_W   = 17;
   localparam int COUNT_W     = 32;
   localparam int LEN_W       = 4;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MOTIF_CODES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WILDCARD_MASK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTIF_LENGTH  = 2'd2;

   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef struct packed {
      logic               op;
      logic [PEP_W-1:0]   peptide;
      logic [BIN_W-1:0]   bin;
      logic [COUNT_W-1:0] count;
   } req_type;

   typedef struct packed {
      logic               matched;
      logic [COUNT_W-1:0] bin_total;
   } rsp_type;

   typedef struct packed {
      logic               op;
      logic               matched;
      logic               in_range;
      logic [BIN_W-1:0]   bin;
      logic [COUNT_W-1:0] count;
   } entry_type;

endpackage

`default_nettype wire

// ===== sv/wmm_fifo.sv =====
// Small first-in first-out queue of fixed-width words.
// Used between the front and back parts and as the result buffer; no dependencies.
`default_nettype none

module wmm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  not_empty,
   output logic                  full
);

   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (PTR_W + 1)'(DEPTH));
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/wmm_front.sv =====
// Front part: motif registers, input word acceptance and motif matching.
// Depends on wmm_pkg.
`default_nettype none

module wmm_front #(
   parameter int NUM_BINS = 2048
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [wmm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [wmm_pkg::PEP_W-1:0]        csr_wdata,
   input  wire logic                             req_valid,
   input  wire wmm_pkg::req_type                 req_data,
   output logic                                  req_stall,
   input  wire logic                             block,
   output logic                                  push,
   output wmm_pkg::entry_type                    entry
);

   import wmm_pkg::*;

   logic [PEP_W-1:0]   motif_ff, motif_in;
   logic [RES_NUM-1:0] wild_ff, wild_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [RES_NUM-1:0] pos_ok;
   logic               match_any;
   logic [BIN_EXT_W-1:0] bin_ext;

   always_comb begin
      motif_in = motif_ff;
      wild_in  = wild_ff;
      len_in   = len_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MOTIF_CODES:   motif_in = csr_wdata;
            CSR_WILDCARD_MASK: wild_in  = csr_wdata[RES_NUM-1:0];
            CSR_MOTIF_LENGTH:  len_in   = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motif_ff <= '0;
         wild_ff  <= '0;
         len_ff   <= '0;
      end else begin
         motif_ff <= motif_in;
         wild_ff  <= wild_in;
         len_ff   <= len_in;
      end
   end

   // Every offset is tested in parallel; positions past the motif length always pass.
   always_comb begin
      match_any = (len_ff == '0);
      pos_ok    = '1;
      for (int j = 0; j < RES_NUM; j++) begin
         pos_ok = '1;
         for (int k = 0; k < RES_NUM - j; k++) begin
            pos_ok[k] = (k >= int'(len_ff)) || wild_ff[k] ||
                        (motif_ff[k*RES_W +: RES_W] == req_data.peptide[(j+k)*RES_W +: RES_W]);
         end
         if ((j + int'(len_ff) <= PEPTIDE_LEN) && (&pos_ok)) begin
            match_any = 1'b1;
         end
      end
   end

   assign bin_ext   = {{(BIN_EXT_W - BIN_W){1'b0}}, req_data.bin};
   assign req_stall = block;
   assign push      = req_valid && !block;

   always_comb begin
      entry.op       = req_data.op;
      entry.matched  = (req_data.op == OP_ACCUM) && match_any;
      entry.in_range = (bin_ext < BIN_EXT_W'(NUM_BINS));
      entry.bin      = req_data.bin;
      entry.count    = req_data.count;
   end

endmodule

`default_nettype wire

// ===== sv/wmm_back.sv =====
// Back part: bin memory with clearing pass, read-modify-write with forwarding,
// and the result buffer. Depends on wmm_pkg and wmm_fifo.
`default_nettype none

module wmm_back #(
   parameter int NUM_BINS = 2048
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire wmm_pkg::entry_type  q_entry,
   output logic                     q_pop,
   output logic                     busy,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output wmm_pkg::rsp_type         rsp_data
);

   import wmm_pkg::*;

   localparam int ADDR_W = $clog2(NUM_BINS);
   localparam int RSP_W  = $bits(rsp_type);

   logic [COUNT_W-1:0] bin_mem_ff [NUM_BINS];

   logic               clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               x_valid_ff, x_valid_in;
   entry_type          x_entry_ff;
   logic [COUNT_W-1:0] rd_data_ff;
   logic               lw_valid_ff, lw_valid_in;
   logic [ADDR_W-1:0]  lw_addr_ff;
   logic [COUNT_W-1:0] lw_data_ff;

   logic               issue;
   logic               x_fire;
   logic               out_full;
   logic               out_pop;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  x_addr;
   logic [BIN_EXT_W-1:0] rd_bin_ext;
   logic [BIN_EXT_W-1:0] x_bin_ext;
   logic [COUNT_W-1:0] cur_val;
   logic [COUNT_W-1:0] sum_val;
   logic               wr_en;
   logic [COUNT_W-1:0] wr_data;
   rsp_type            result;
   logic [RSP_W-1:0]   out_bits;

   assign rd_bin_ext = {{(BIN_EXT_W - BIN_W){1'b0}}, q_entry.bin};
   assign x_bin_ext  = {{(BIN_EXT_W - BIN_W){1'b0}}, x_entry_ff.bin};
   assign rd_addr    = rd_bin_ext[ADDR_W-1:0];
   assign x_addr     = x_bin_ext[ADDR_W-1:0];

   assign busy   = clr_active_ff;
   assign x_fire = x_valid_ff && !out_full;
   assign issue  = q_valid && !clr_active_ff && (!x_valid_ff || x_fire);
   assign q_pop  = issue;

   // The last write may land on the edge that read this word, so it takes priority.
   assign cur_val = (lw_valid_ff && (lw_addr_ff == x_addr)) ? lw_data_ff : rd_data_ff;
   assign sum_val = cur_val + x_entry_ff.count;

   always_comb begin
      result.matched = x_entry_ff.matched;
      wr_en          = 1'b0;
      wr_data        = sum_val;
      unique case (x_entry_ff.op)
         OP_ACCUM: begin
            result.bin_total = x_entry_ff.in_range ?
                               (x_entry_ff.matched ? sum_val : cur_val) : '0;
            wr_en            = x_fire && x_entry_ff.in_range && x_entry_ff.matched;
            wr_data          = sum_val;
         end
         OP_READ: begin
            result.bin_total = x_entry_ff.in_range ? cur_val : '0;
            wr_en            = x_fire && x_entry_ff.in_range;
            wr_data          = '0;
         end
         default: begin
            result.bin_total = '0;
         end
      endcase
   end

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(NUM_BINS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
      x_valid_in = issue || (x_valid_ff && !x_fire);
      lw_valid_in = clr_active_ff ? 1'b0 : (lw_valid_ff || wr_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         x_valid_ff    <= 1'b0;
         lw_valid_ff   <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         x_valid_ff    <= x_valid_in;
         lw_valid_ff   <= lw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         x_entry_ff <= q_entry;
      end
      if (wr_en) begin
         lw_addr_ff <= x_addr;
         lw_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         bin_mem_ff[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         bin_mem_ff[x_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= bin_mem_ff[rd_addr];
      end
   end

   assign out_pop = rsp_valid && !rsp_stall;

   wmm_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (x_fire),
      .push_data (result),
      .pop       (out_pop),
      .pop_data  (out_bits),
      .not_empty (rsp_valid),
      .full      (out_full)
   );

   assign rsp_data = rsp_type'(out_bits);

endmodule

`default_nettype wire

// ===== sv/wildcard_motif_match_count_accumulate_top.sv =====
// Wildcard motif match and per-bin count accumulator, top level.
// Accepts one word per cycle unless req_stall is high; a taken request passes the input queue, the
// x stage and the result buffer. Sustained rate with rsp_stall low is one word per cycle: the bin
// memory takes one read and one write a cycle. Reset clears the motif registers and then sweeps the
// bin memory one bin per cycle with req_stall high; csr writes are taken during the sweep.
`default_nettype none

module wildcard_motif_match_count_accumulate_top #(
   parameter int NUM_BINS = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [wmm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [wmm_pkg::PEP_W-1:0]     csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire wmm_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output wmm_pkg::rsp_type                   rsp_data
);

   import wmm_pkg::*;

   localparam int ENTRY_W = $bits(entry_type);

   logic             front_block;
   logic             q_push;
   entry_type        q_in_entry;
   logic [ENTRY_W-1:0] q_out_bits;
   logic             q_valid;
   logic             q_full;
   logic             q_pop;
   logic             back_busy;

   assign front_block = back_busy || q_full;

   wmm_front #(
      .NUM_BINS (NUM_BINS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .block     (front_block),
      .push      (q_push),
      .entry     (q_in_entry)
   );

   wmm_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_entry),
      .pop       (q_pop),
      .pop_data  (q_out_bits),
      .not_empty (q_valid),
      .full      (q_full)
   );

   wmm_back #(
      .NUM_BINS (NUM_BINS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (entry_type'(q_out_bits)),
      .q_pop     (q_pop),
      .busy      (back_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== verif/wmm_count_check.sv =====
// Result checker for the wildcard motif match and count accumulate block.
// Tracks the motif registers and bin totals, predicts each result word and compares it.
// Depends on wmm_pkg for the word types, register indexes and operation codes.

module wmm_count_check #(
   parameter int NUM_BINS = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [wmm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wmm_pkg::PEP_W-1:0]     csr_wdata,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  wmm_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  wmm_pkg::rsp_type              rsp_data,
   output int                            fail_count,
   output int                            pending_count,
   output int                            word_count,
   output int                            hit_count,
   output int                            read_count
);

   import wmm_pkg::*;

   logic [PEP_W-1:0]   motif_codes;
   logic [RES_NUM-1:0] wildcard_mask;
   logic [LEN_W-1:0]   motif_len;
   logic [COUNT_W-1:0] bin_store [NUM_BINS];
   rsp_type            expected_totals [$];
   int                 fails;
   int                 words;
   int                 hits;
   int                 reads;

   function automatic logic motif_hit(input logic [PEP_W-1:0] pep);
      logic ok;
      if (motif_len == 0) return 1'b1;
      if (motif_len > PEPTIDE_LEN) return 1'b0;
      for (int j = 0; j + motif_len <= PEPTIDE_LEN; j++) begin
         ok = 1'b1;
         for (int k = 0; k < motif_len; k++) begin
            if (!wildcard_mask[k] &&
                motif_codes[RES_W*k +: RES_W] != pep[RES_W*(j+k) +: RES_W]) begin
               ok = 1'b0;
            end
         end
         if (ok) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type update_bin_totals(input req_type w);
      rsp_type r;
      logic    in_range;
      r = '0;
      in_range = int'(w.bin) < NUM_BINS;
      if (w.op == OP_READ) begin
         if (in_range) begin
            r.bin_total = bin_store[w.bin];
            bin_store[w.bin] = '0;
         end
      end else begin
         r.matched = motif_hit(w.peptide);
         if (in_range) begin
            if (r.matched) bin_store[w.bin] = bin_store[w.bin] + w.count;
            r.bin_total = bin_store[w.bin];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         motif_codes = '0;
         wildcard_mask = '0;
         motif_len = '0;
         for (int i = 0; i < NUM_BINS; i++) bin_store[i] = '0;
         expected_totals.delete();
         fails = 0;
         words = 0;
         hits = 0;
         reads = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_totals.size() == 0) begin
               $display("%0t: result word with none expected: matched %0b bin_total %h",
                        $time, rsp_data.matched, rsp_data.bin_total);
               fails++;
            end else begin
               want = expected_totals.pop_front();
               if (rsp_data.matched !== want.matched) begin
                  $display("%0t: matched mismatch: expected %0b, actual %0b",
                           $time, want.matched, rsp_data.matched);
                  fails++;
               end
               if (rsp_data.bin_total !== want.bin_total) begin
                  $display("%0t: bin_total mismatch: expected %h, actual %h",
                           $time, want.bin_total, rsp_data.bin_total);
                  fails++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MOTIF_CODES:   motif_codes = csr_wdata;
               CSR_WILDCARD_MASK: wildcard_mask = csr_wdata[RES_NUM-1:0];
               CSR_MOTIF_LENGTH:  motif_len = csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want = update_bin_totals(req_data);
            expected_totals.insert(expected_totals.size(), want);
            words++;
            if (req_data.op == OP_READ) reads++;
            else if (want.matched) hits++;
         end
      end
      fail_count <= fails;
      pending_count <= expected_totals.size();
      word_count <= words;
      hit_count <= hits;
      read_count <= reads;
   end

endmodule

// ===== verif/wildcard_motif_match_count_accumulate_top_tb.sv =====
// Testbench top for the wildcard motif match and count accumulate block.
// Drives directed and random words under several motif settings and idling mixes;
// depends on wmm_pkg, the block's top level and the wmm_count_check result checker.

module wildcard_motif_match_count_accumulate_top_tb;
   import wmm_pkg::*;

   localparam int NUM_BINS      = 2048;
   localparam int RESET_CYCLES  = 6;
   localparam int DRAIN_CYCLES  = 4;
   localparam int IDLE_LIMIT    = 4 * NUM_BINS + 1000;
   localparam int SEGMENTS      = 6;
   localparam int SEGMENT_WORDS = 36;
   localparam int HOT_BINS      = 8;
   localparam int BIN_MAX       = (1 << BIN_W) - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PEP_W-1:0]     csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;

   int fail_count;
   int pending_count;
   int word_count;
   int hit_count;
   int read_count;
   int send_idle_pct = 38;
   int recv_idle_pct = 65;
   int idle_cycles = 0;
   int motif_settings = 0;

   logic [PEP_W-1:0]   cur_codes;
   logic [RES_NUM-1:0] cur_mask;
   logic [LEN_W-1:0]   cur_len;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   wildcard_motif_match_count_accumulate_top #(
      .NUM_BINS(NUM_BINS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   wmm_count_check #(
      .NUM_BINS(NUM_BINS)
   ) i_count_check (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .word_count(word_count),
      .hit_count(hit_count),
      .read_count(read_count)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word accepted for %0d cycles", $time, idle_cycles);
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [PEP_W-1:0] random_peptide();
      logic [PEP_W-1:0] p;
      for (int i = 0; i < RES_NUM; i++) begin
         if ($urandom_range(7) == 0) p[RES_W*i +: RES_W] = RES_W'($urandom_range(31));
         else p[RES_W*i +: RES_W] = RES_W'($urandom_range(19));
      end
      return p;
   endfunction

   function automatic logic [PEP_W-1:0] place_motif(input logic [PEP_W-1:0] base,
                                                     input int off);
      for (int k = 0; k < cur_len; k++) begin
         if (!cur_mask[k]) base[RES_W*(off+k) +: RES_W] = cur_codes[RES_W*k +: RES_W];
      end
      return base;
   endfunction

   function automatic req_type make_word(input logic op, input logic [PEP_W-1:0] pep,
                                         input int bin, input logic [COUNT_W-1:0] count);
      req_type w;
      w.op = op;
      w.peptide = pep;
      w.bin = BIN_W'(bin);
      w.count = count;
      return w;
   endfunction

   task automatic pass_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_and_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_motif(input logic [PEP_W-1:0] codes, input logic [RES_NUM-1:0] mask,
                              input logic [LEN_W-1:0] len);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      csr_we <= 1'b1;
      csr_index <= CSR_MOTIF_CODES;
      csr_wdata <= codes;
      @(posedge clock);
      csr_index <= CSR_WILDCARD_MASK;
      csr_wdata <= {junk[PEP_W-1:RES_NUM], mask};
      @(posedge clock);
      csr_index <= CSR_MOTIF_LENGTH;
      csr_wdata <= {junk[PEP_W-1:LEN_W], len};
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= junk[PEP_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      cur_codes = codes;
      cur_mask = mask;
      cur_len = len;
      motif_settings++;
   endtask

   task automatic load_random_motif();
      logic [LEN_W-1:0] len;
      case ($urandom_range(9))
         0: len = '0;
         1: len = LEN_W'(PEPTIDE_LEN);
         2: len = LEN_W'($urandom_range(15, PEPTIDE_LEN + 1));
         default: len = LEN_W'($urandom_range(PEPTIDE_LEN - 1, 1));
      endcase
      write_motif(random_peptide(), RES_NUM'($urandom & $urandom), len);
   endtask

   function automatic int pick_bin();
      if ($urandom_range(9) == 0) return $urandom_range(BIN_MAX);
      return $urandom_range(HOT_BINS - 1);
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(6))
         0: return $urandom_range(15);
         1: return 32'hFFFF_FFF0 + $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   task automatic run_random_words(input int n, input logic pause_midway);
      req_type w;
      int      pick;
      int      off;
      int      k;
      for (int i = 0; i < n; i++) begin
         if (pause_midway && i == n / 2) drain_and_wait();
         pick = $urandom_range(99);
         w = make_word(OP_ACCUM, random_peptide(), pick_bin(), pick_count());
         if (pick < 20) begin
            w.op = OP_READ;
         end else if (pick < 75 && cur_len != 0 && cur_len <= PEPTIDE_LEN) begin
            off = $urandom_range(PEPTIDE_LEN - cur_len);
            w.peptide = place_motif(w.peptide, off);
            if (pick < 35) begin
               k = $urandom_range(cur_len - 1);
               if (!cur_mask[k]) begin
                  w.peptide[RES_W*(off+k) +: RES_W] =
                     cur_codes[RES_W*k +: RES_W] + 5'($urandom_range(31, 1));
               end
            end
         end
         pass_word(w);
      end
   endtask

   initial begin
      logic [PEP_W-1:0] codes;
      logic [PEP_W-1:0] pep;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_MOTIF_CODES;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_data = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // With the reset motif of length zero every peptide matches.
      pass_word(make_word(OP_ACCUM, '0, 0, 32'hFFFF_FFFF));
      pass_word(make_word(OP_ACCUM, '1, 0, 32'd2));
      pass_word(make_word(OP_ACCUM, random_peptide(), BIN_MAX, 32'd0));
      pass_word(make_word(OP_READ, '0, 0, 32'd0));
      pass_word(make_word(OP_READ, '1, 0, 32'hFFFF_FFFF));
      pass_word(make_word(OP_READ, '0, BIN_MAX, 32'd0));

      // A four-position motif with a wildcard, a code above 19 and mask bits past its end.
      drain_and_wait();
      codes = random_peptide();
      codes[RES_W*0 +: RES_W] = 5'd3;
      codes[RES_W*2 +: RES_W] = 5'd25;
      codes[RES_W*3 +: RES_W] = 5'd19;
      write_motif(codes, 12'hFF2, 4'd4);
      pass_word(make_word(OP_ACCUM, place_motif(random_peptide(), 0), 3, 32'd100));
      pass_word(make_word(OP_ACCUM, place_motif(random_peptide(), 8), 3, 32'hFFFF_FFFF));
      // The last motif position is changed, so no offset can match.
      pep = place_motif('0, 2);
      pep[RES_W*5 +: RES_W] = 5'd18;
      pass_word(make_word(OP_ACCUM, pep, 3, 32'd7));
      pass_word(make_word(OP_READ, pep, 3, 32'd0));

      drain_and_wait();
      write_motif(random_peptide(), '0, LEN_W'(PEPTIDE_LEN));
      pass_word(make_word(OP_ACCUM, cur_codes, 4, 32'h8000_0000));
      pep = cur_codes;
      pep[PEP_W-1 -: RES_W] = pep[PEP_W-1 -: RES_W] + 5'd1;
      pass_word(make_word(OP_ACCUM, pep, 4, 32'd1));
      pass_word(make_word(OP_READ, '0, 4, 32'd0));

      // Lengths past the peptide never match, even against an equal peptide.
      drain_and_wait();
      write_motif(random_peptide(), '0, 4'd13);
      pass_word(make_word(OP_ACCUM, cur_codes, 5, 32'd9));
      drain_and_wait();
      write_motif(random_peptide(), '1, 4'd15);
      pass_word(make_word(OP_ACCUM, random_peptide(), 5, 32'd9));

      drain_and_wait();
      write_motif('1, '1, 4'd1);
      pass_word(make_word(OP_ACCUM, random_peptide(), BIN_MAX, 32'd5));
      pass_word(make_word(OP_READ, '0, BIN_MAX, 32'd0));

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 65 : 0;
         recv_idle_pct <= (mode == 0) ? 65 : (mode == 1) ? 38 : 0;
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain_and_wait();
            load_random_motif();
            run_random_words(SEGMENT_WORDS, seg == 0);
         end
      end
      drain_and_wait();

      $display("Checked %0d words under %0d motif settings: %0d matched accumulates, %0d reads.",
               word_count, motif_settings, hit_count, read_count);
      $display("Idling ran sender-heavy, receiver-heavy and with none, with full drains.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/wmm_pkg.sv
sv/wmm_fifo.sv
sv/wmm_front.sv
sv/wmm_back.sv
sv/wildcard_motif_match_count_accumulate_top.sv
verif/wmm_count_check.sv
verif/wildcard_motif_match_count_accumulate_top_tb.sv
